// ===== rtl/core/srrip_pkg.sv =====
`default_nettype none
// ============================================================================
// srrip_pkg
// Shared types and constants of the SRRIP replacement block with per-set
// dynamic bypass.
// ============================================================================
package srrip_pkg;

    // Geometry
    localparam int NUM_SETS   = 2048;
    localparam int NUM_WAYS   = 16;
    localparam int WINDOW     = 128;
    localparam int VALUE_BITS = 2;

    localparam int SET_BITS  = $clog2(NUM_SETS);
    localparam int WAY_BITS  = 4;
    localparam int ACC_BITS  = $clog2(WINDOW);
    localparam int MISS_BITS = $clog2(WINDOW + 1);
    localparam int BYTE_BITS = 8;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    // Configuration register widths
    localparam int THRESH_BITS = 8;
    localparam int CUTOFF_BITS = 9;
    localparam int INSERT_BITS = 2;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_MISS_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BYPASS_CUTOFF  = 2'd1;
    localparam logic [1:0] REG_INSERT_VALUE   = 2'd2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd89;
    localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = 9'd128;
    localparam logic [INSERT_BITS-1:0] INSERT_RESET = 2'd2;

    // Request opcodes
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // One memory word: everything kept for a set
    typedef struct packed {
        logic                                 bypass_flag;
        logic [MISS_BITS-1:0]                 misses;
        logic [ACC_BITS-1:0]                  accesses;
        logic [NUM_WAYS-1:0][VALUE_BITS-1:0]  reref;
    } t_set_entry;

    localparam t_set_entry ENTRY_RESET = '{
        bypass_flag: 1'b0,
        misses:      '0,
        accesses:    '0,
        reref:       {NUM_WAYS{VALUE_MAX}}
    };

    // Request captured at accept
    typedef struct packed {
        logic                 opcode;
        logic [SET_BITS-1:0]  set_index;
        logic [WAY_BITS-1:0]  way;
        logic                 hit;
        logic [BYTE_BITS-1:0] addr_low_byte;
        logic [BYTE_BITS-1:0] pc_low_byte;
    } t_request;

    // Result of one item
    typedef struct packed {
        logic [WAY_BITS-1:0] victim_way;
        logic                bypassed;
        logic                set_bypass_on;
    } t_result;

    // Configuration values
    typedef struct packed {
        logic [THRESH_BITS-1:0] miss_threshold;
        logic [CUTOFF_BITS-1:0] bypass_cutoff;
        logic [INSERT_BITS-1:0] insert_value;
    } t_config;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/srrip_rmw.sv =====
`default_nettype none
// ============================================================================
// srrip_rmw
// Modify step of the set read-modify-write: victim selection with aging,
// window statistics, bypass decision and way promotion or insertion.
// ============================================================================
module srrip_rmw import srrip_pkg::*; (
    input  wire t_set_entry           i_entry,
    input  wire t_request             i_req,
    input  wire t_config              i_cfg,
    input  wire logic [BYTE_BITS-1:0] i_hit_cnt,
    input  wire logic [BYTE_BITS-1:0] i_miss_cnt,
    output t_set_entry                o_entry,
    output logic [BYTE_BITS-1:0]      o_hit_cnt,
    output logic [BYTE_BITS-1:0]      o_miss_cnt,
    output t_result                   o_result
);

    logic [VALUE_BITS-1:0] top;
    logic [NUM_WAYS-1:0]   cand;
    logic [VALUE_BITS-1:0] shortfall;
    logic [WAY_BITS-1:0]   victim;

    logic [ACC_BITS:0]     acc_inc;
    logic [MISS_BITS-1:0]  miss_inc;
    logic                  window_done;
    logic                  flag_new;
    logic [BYTE_BITS-1:0]  hash;
    logic                  byp;

    // Maximum value by bit planes, MSB first; cand ends as ways equal to top
    always_comb begin
        logic [NUM_WAYS-1:0] plane;
        top  = '0;
        cand = '1;
        for (int b = VALUE_BITS - 1; b >= 0; b--) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                plane[w] = cand[w] & i_entry.reref[w][b];
            end
            if (|plane) begin
                top[b] = 1'b1;
                cand   = plane;
            end
        end
    end

    // After aging by the shortfall the lowest way at top reaches the maximum
    assign shortfall = VALUE_MAX - top;

    always_comb begin
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (cand[w]) begin
                victim = WAY_BITS'(w);
            end
        end
    end

    // Window statistics and global counters
    assign acc_inc     = {1'b0, i_entry.accesses} + 1'b1;
    assign miss_inc    = i_entry.misses + MISS_BITS'(!i_req.hit);
    assign window_done = acc_inc >= (ACC_BITS + 1)'(WINDOW);
    assign o_hit_cnt   = i_hit_cnt + BYTE_BITS'(i_req.hit);
    assign o_miss_cnt  = i_miss_cnt + BYTE_BITS'(!i_req.hit);

    assign flag_new = window_done ? (miss_inc > i_cfg.miss_threshold)
                                  : i_entry.bypass_flag;

    // Bypass hash over the updated counters
    assign hash = i_req.addr_low_byte ^ i_req.pc_low_byte ^ o_hit_cnt ^ o_miss_cnt;
    assign byp  = !i_req.hit && flag_new && ({1'b0, hash} < i_cfg.bypass_cutoff);

    // New memory word
    always_comb begin
        o_entry = i_entry;
        if (i_req.opcode == OP_VICTIM) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                o_entry.reref[w] = i_entry.reref[w] + shortfall;
            end
        end else begin
            o_entry.bypass_flag = flag_new;
            if (window_done) begin
                o_entry.accesses = '0;
                o_entry.misses   = '0;
            end else begin
                o_entry.accesses = acc_inc[ACC_BITS-1:0];
                o_entry.misses   = miss_inc;
            end
            // the 4-bit way field always addresses one of the 16 ways
            if (i_req.hit) begin
                o_entry.reref[i_req.way] = '0;
            end else if (!byp) begin
                o_entry.reref[i_req.way] = i_cfg.insert_value;
            end
        end
    end

    // Result fields
    always_comb begin
        if (i_req.opcode == OP_VICTIM) begin
            o_result.victim_way    = victim;
            o_result.bypassed      = 1'b0;
            o_result.set_bypass_on = i_entry.bypass_flag;
        end else begin
            o_result.victim_way    = '0;
            o_result.bypassed      = byp;
            o_result.set_bypass_on = flag_new;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/srrip_replacement_with_set_bypass_top.sv =====
`default_nettype none
// ============================================================================
// srrip_replacement_with_set_bypass_top
// SRRIP replacement policy with 2-bit re-reference values per way and a
// per-set dynamic bypass flag, built around one set memory.
// ============================================================================
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  --------------------------------
//  in        to block   i_in_valid / o_in_stall  opcode, set_index, way, hit,
//                                                addr_low_byte, pc_low_byte
//  out       from block o_out_valid/i_out_stall  victim_way, bypassed,
//                                                set_bypass_on
//  cfg       APB        psel/penable/pready      miss_threshold, bypass_cutoff,
//                                                insert_value
//
//  An item passes through the set memory read, then modify and write back of the
//  whole set word. One item is in flight at a time.
//  After reset a clearing pass writes all NUM_SETS (2048) set words, during
//  which no item is accepted; configuration writes are taken.
//  A stalled result sits in the output register while the next item is read;
//  that item waits in the modify step until the output register frees.
// ============================================================================
module srrip_replacement_with_set_bypass_top import srrip_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_opcode,
    input  wire logic [SET_BITS-1:0]   i_set_index,
    input  wire logic [WAY_BITS-1:0]   i_way,
    input  wire logic                  i_hit,
    input  wire logic [BYTE_BITS-1:0]  i_addr_low_byte,
    input  wire logic [BYTE_BITS-1:0]  i_pc_low_byte,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [WAY_BITS-1:0]        o_victim_way,
    output logic                       o_bypassed,
    output logic                       o_set_bypass_on,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_state               r_state, n_state;
    logic [SET_BITS-1:0]  r_clr_idx;
    t_request             r_req;
    t_set_entry           r_rdata;
    t_config              r_cfg;
    logic [BYTE_BITS-1:0] r_hit_cnt;
    logic [BYTE_BITS-1:0] r_miss_cnt;
    logic                 r_out_valid;
    t_result              r_result;

    t_set_entry           mem [NUM_SETS];

    t_set_entry           new_entry;
    logic [BYTE_BITS-1:0] n_hit_cnt;
    logic [BYTE_BITS-1:0] n_miss_cnt;
    t_result              new_result;

    logic                 in_accept;
    logic                 out_free;
    logic                 commit;
    logic                 clr_wr;
    logic                 clr_last;
    logic                 cfg_wr;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.miss_threshold <= THRESH_RESET;
            r_cfg.bypass_cutoff  <= CUTOFF_RESET;
            r_cfg.insert_value   <= INSERT_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MISS_THRESHOLD: r_cfg.miss_threshold <= pwdata[THRESH_BITS-1:0];
                REG_BYPASS_CUTOFF:  r_cfg.bypass_cutoff  <= pwdata[CUTOFF_BITS-1:0];
                REG_INSERT_VALUE:   r_cfg.insert_value   <= pwdata[INSERT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_MISS_THRESHOLD: prdata = {{(32-THRESH_BITS){1'b0}}, r_cfg.miss_threshold};
            REG_BYPASS_CUTOFF:  prdata = {{(32-CUTOFF_BITS){1'b0}}, r_cfg.bypass_cutoff};
            REG_INSERT_VALUE:   prdata = {{(32-INSERT_BITS){1'b0}}, r_cfg.insert_value};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_accept = i_in_valid && !o_in_stall;
    assign clr_last  = r_clr_idx == SET_BITS'(NUM_SETS - 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last)   n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC:  if (out_free)   n_state = ST_IDLE;
            default:                  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        commit     = 1'b0;
        clr_wr     = 1'b0;
        case (r_state)
            ST_CLEAR: clr_wr     = 1'b1;
            ST_IDLE:  o_in_stall = 1'b0;
            ST_EXEC:  commit     = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (clr_wr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.opcode        <= i_opcode;
            r_req.set_index     <= i_set_index;
            r_req.way           <= i_way;
            r_req.hit           <= i_hit;
            r_req.addr_low_byte <= i_addr_low_byte;
            r_req.pc_low_byte   <= i_pc_low_byte;
        end
    end

    // ------------------------------------------------------------------
    // Set memory: read on accept, write on commit or clearing pass
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rdata <= mem[i_set_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_wr) begin
            mem[r_clr_idx] <= ENTRY_RESET;
        end else if (commit) begin
            mem[r_req.set_index] <= new_entry;
        end
    end

    // ------------------------------------------------------------------
    // Modify step
    // ------------------------------------------------------------------
    srrip_rmw u_rmw (
        .i_entry    (r_rdata),
        .i_req      (r_req),
        .i_cfg      (r_cfg),
        .i_hit_cnt  (r_hit_cnt),
        .i_miss_cnt (r_miss_cnt),
        .o_entry    (new_entry),
        .o_hit_cnt  (n_hit_cnt),
        .o_miss_cnt (n_miss_cnt),
        .o_result   (new_result)
    );

    // global hit and miss counters, low bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else if (commit && r_req.opcode == OP_UPDATE) begin
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_result <= new_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_victim_way    = r_result.victim_way;
    assign o_bypassed      = r_result.bypassed;
    assign o_set_bypass_on = r_result.set_bypass_on;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: SRRIP replacement with per-set bypass
// Drives victim requests and access updates through the request channel under
// random bursts and gaps while the result channel stalls on its own pattern.
// Each accepted request is run through a local model of the replacement
// state, and every result is compared field by field in order. Several
// register settings are used, the extremes among them, with read-back.
// ----------------------------------------------------------------------------
module tb;
    import srrip_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // Clock, reset and block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_stall;
    t_request             cur_req = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    logic [WAY_BITS-1:0]  o_victim_way;
    logic                 o_bypassed;
    logic                 o_set_bypass_on;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Model of the replacement state and registers
    logic [VALUE_BITS-1:0]  rrpv_model [NUM_SETS][NUM_WAYS];
    int unsigned            win_accesses [NUM_SETS];
    int unsigned            win_misses [NUM_SETS];
    bit                     set_flag [NUM_SETS];
    logic [7:0]             model_hit_cnt;
    logic [7:0]             model_miss_cnt;
    logic [THRESH_BITS-1:0] cfg_threshold = THRESH_RESET;
    logic [CUTOFF_BITS-1:0] cfg_cutoff = CUTOFF_RESET;
    logic [INSERT_BITS-1:0] cfg_insert = INSERT_RESET;

    t_request request_queue [$];
    t_result  expected_results [$];
    t_result  want;
    int       err_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       stall_mode = 0;
    int       hot_a;
    int       hot_b;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    srrip_replacement_with_set_bypass_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (cur_req.opcode),
        .i_set_index     (cur_req.set_index),
        .i_way           (cur_req.way),
        .i_hit           (cur_req.hit),
        .i_addr_low_byte (cur_req.addr_low_byte),
        .i_pc_low_byte   (cur_req.pc_low_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_victim_way    (o_victim_way),
        .o_bypassed      (o_bypassed),
        .o_set_bypass_on (o_set_bypass_on),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Replacement model: applies one request, returns its result
    function automatic t_result predict_srrip(input t_request r);
        t_result               res;
        logic [VALUE_BITS-1:0] top;
        logic [7:0]            hash;
        int                    s;
        res = '0;
        s = r.set_index;
        if (r.opcode == OP_VICTIM) begin
            top = '0;
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv_model[s][w] > top) top = rrpv_model[s][w];
            // age the whole set so that some way reaches the maximum
            if (top != VALUE_MAX)
                for (int w = 0; w < NUM_WAYS; w++)
                    rrpv_model[s][w] = rrpv_model[s][w] + (VALUE_MAX - top);
            for (int w = NUM_WAYS - 1; w >= 0; w--)
                if (rrpv_model[s][w] == VALUE_MAX) res.victim_way = WAY_BITS'(w);
        end else begin
            win_accesses[s]++;
            if (r.hit) begin
                model_hit_cnt++;
            end else begin
                win_misses[s]++;
                model_miss_cnt++;
            end
            // window closes: decide the bypass flag
            if (win_accesses[s] >= WINDOW) begin
                set_flag[s] = (win_misses[s] > cfg_threshold);
                win_accesses[s] = 0;
                win_misses[s] = 0;
            end
            if (r.hit) begin
                rrpv_model[s][r.way] = '0;
            end else begin
                if (set_flag[s]) begin
                    hash = r.addr_low_byte ^ r.pc_low_byte ^ model_hit_cnt ^ model_miss_cnt;
                    res.bypassed = ({1'b0, hash} < cfg_cutoff);
                end
                if (!res.bypassed) rrpv_model[s][r.way] = cfg_insert;
            end
        end
        res.set_bypass_on = set_flag[s];
        return res;
    endfunction

    function automatic t_request mk_req(input logic op, input int set_i, input int way_i,
                                        input logic hit_i, input int addr_i, input int pc_i);
        t_request r;
        r.opcode        = op;
        r.set_index     = SET_BITS'(set_i);
        r.way           = WAY_BITS'(way_i);
        r.hit           = hit_i;
        r.addr_low_byte = BYTE_BITS'(addr_i);
        r.pc_low_byte   = BYTE_BITS'(pc_i);
        return r;
    endfunction

    // Random request, mostly aimed at two hot sets so windows close
    function automatic t_request random_item(input int miss_pct);
        t_request r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)      r.set_index = SET_BITS'(hot_a);
        else if (pick < 85) r.set_index = SET_BITS'(hot_b);
        else                r.set_index = SET_BITS'($urandom_range(0, NUM_SETS - 1));
        r.opcode        = ($urandom_range(0, 9) < 3) ? OP_VICTIM : OP_UPDATE;
        r.way           = WAY_BITS'($urandom_range(0, NUM_WAYS - 1));
        r.hit           = ($urandom_range(0, 99) >= miss_pct);
        r.addr_low_byte = BYTE_BITS'($urandom_range(0, 255));
        r.pc_low_byte   = BYTE_BITS'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic fill_random(input int miss_pct, input int count);
        t_request r;
        int       n;
        n = 0;
        while (n < count) begin
            r = random_item(miss_pct);
            if ($urandom_range(0, 3) == 0) begin
                // fill flow: victim lookup, then the miss fill into that set
                r.opcode = OP_VICTIM;
                request_queue.push_back(r);
                r.opcode = OP_UPDATE;
                r.hit = 1'b0;
                request_queue.push_back(r);
                n += 2;
            end else begin
                request_queue.push_back(r);
                n++;
            end
        end
    endtask

    // Wait for all items sent and all results back
    task automatic wait_quiet();
        while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] reg_mask(input logic [1:0] idx);
        case (idx)
            REG_MISS_THRESHOLD: return (32'd1 << THRESH_BITS) - 1;
            REG_BYPASS_CUTOFF:  return (32'd1 << CUTOFF_BITS) - 1;
            default:            return (32'd1 << INSERT_BITS) - 1;
        endcase
    endfunction

    // APB write; junk above the register width must be dropped
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] word;
        word = ($urandom & ~reg_mask(idx)) | (value & reg_mask(idx));
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MISS_THRESHOLD: cfg_threshold = word[THRESH_BITS-1:0];
            REG_BYPASS_CUTOFF:  cfg_cutoff = word[CUTOFF_BITS-1:0];
            default:            cfg_insert = word[INSERT_BITS-1:0];
        endcase
    endtask

    task automatic read_check(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== value) begin
            err_count++;
            $display("%0t: register %0d expected %0h actual %0h", $time, idx, value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int thresh, input int cutoff, input int ins,
                             input int miss_pct, input int count);
        wait_quiet();
        write_reg(REG_MISS_THRESHOLD, thresh);
        write_reg(REG_BYPASS_CUTOFF, cutoff);
        write_reg(REG_INSERT_VALUE, ins);
        read_check(REG_MISS_THRESHOLD, cfg_threshold);
        read_check(REG_BYPASS_CUTOFF, cfg_cutoff);
        read_check(REG_INSERT_VALUE, cfg_insert);
        fill_random(miss_pct, count);
    endtask

    // Request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall)
                expected_results.push_back(predict_srrip(cur_req));
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    cur_req  <= request_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: free-flowing, light or heavy, switched every so often
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                err_count++;
                $display("%0t: result with none expected: victim %0d bypassed %0b flag %0b",
                         $time, o_victim_way, o_bypassed, o_set_bypass_on);
            end else begin
                want = expected_results.pop_front();
                if (o_victim_way !== want.victim_way) begin
                    err_count++;
                    $display("%0t: victim_way expected %0d actual %0d",
                             $time, want.victim_way, o_victim_way);
                end
                if (o_bypassed !== want.bypassed) begin
                    err_count++;
                    $display("%0t: bypassed expected %0b actual %0b",
                             $time, want.bypassed, o_bypassed);
                end
                if (o_set_bypass_on !== want.set_bypass_on) begin
                    err_count++;
                    $display("%0t: set_bypass_on expected %0b actual %0b",
                             $time, want.set_bypass_on, o_set_bypass_on);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) rrpv_model[s][w] = VALUE_MAX;
            win_accesses[s] = 0;
            win_misses[s] = 0;
            set_flag[s] = 1'b0;
        end
        model_hit_cnt = '0;
        model_miss_cnt = '0;
        hot_a = $urandom_range(1, NUM_SETS - 2);
        hot_b = $urandom_range(0, 1) ? NUM_SETS - 1 : 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the registers
        read_check(REG_MISS_THRESHOLD, THRESH_RESET);
        read_check(REG_BYPASS_CUTOFF, CUTOFF_RESET);
        read_check(REG_INSERT_VALUE, INSERT_RESET);

        // fresh set gives way 0; hit promotes, miss inserts at the insert value
        request_queue.push_back(mk_req(OP_VICTIM, 0, 0, 1'b0, 0, 0));
        request_queue.push_back(mk_req(OP_UPDATE, 0, 0, 1'b1, 255, 0));
        request_queue.push_back(mk_req(OP_VICTIM, 0, 9, 1'b1, 0, 255));
        request_queue.push_back(mk_req(OP_UPDATE, 0, 15, 1'b0, 255, 255));
        request_queue.push_back(mk_req(OP_VICTIM, 0, 15, 1'b0, 0, 0));
        // promote every way of the top set, then a victim has to age the set
        for (int w = 0; w < NUM_WAYS; w++)
            request_queue.push_back(mk_req(OP_UPDATE, NUM_SETS - 1, w, 1'b1,
                                           (w % 2) ? 255 : 0, (w % 3) ? 0 : 255));
        request_queue.push_back(mk_req(OP_VICTIM, NUM_SETS - 1, 0, 1'b1, 0, 0));
        request_queue.push_back(mk_req(OP_UPDATE, NUM_SETS - 1, 0, 1'b0, 170, 85));
        request_queue.push_back(mk_req(OP_VICTIM, NUM_SETS - 1, 0, 1'b0, 85, 170));
        fill_random(80, 270);

        // always bypass once a window has any miss, insert at 0
        run_phase(0, 256, 0, 60, 272);
        // flags never set, nothing bypassed, insert at the maximum
        run_phase(255, 0, 3, 90, 272);
        // flag needs a window of nothing but misses, every miss bypassed
        run_phase(127, 511, 1, 97, 272);
        run_phase($urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 3),
                  75, 272);
        run_phase(64, 200, 2, 50, 272);

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/srrip_pkg.sv
rtl/core/srrip_rmw.sv
rtl/core/srrip_replacement_with_set_bypass_top.sv
test/tb.sv
